// ----- sv/acctr_pkg.sv -----
`default_nettype none
package acctr_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int GUARD_SHIFT     = 20;
  localparam int DATA_W          = 40;
  localparam int ANG_W           = 34;
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ROLL_W          = 16;
  localparam int PITCH_W         = 15;
  localparam int GAIN_W          = 17;
  localparam int PROD_W          = DATA_W + GAIN_W;
  localparam int INV_GAIN_SHIFT  = 16;
  localparam int OUT_SHIFT       = 30 - ANGLE_FRAC_BITS;
  localparam int RND_W           = ANG_W - OUT_SHIFT;

  localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(39796);

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint RND_HALF    = 64'd1 << (OUT_SHIFT - 1);

  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = ANG_W'(HALF_PI_Q30);
  localparam logic signed [ANG_W-1:0] RND_HALF_ANG = ANG_W'(RND_HALF);
  localparam logic signed [RND_W-1:0] ROLL_LIM  = RND_W'((PI_Q30 + RND_HALF) >> OUT_SHIFT);
  localparam logic signed [RND_W-1:0] PITCH_LIM =
    RND_W'((HALF_PI_Q30 + RND_HALF) >> OUT_SHIFT);

  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic signed [ANG_W-1:0]    ang_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t raw_x;
    ang_t    roll_ang;
  } side_t;

  function automatic ang_t atan_q30(input int k);
    ang_t r;
    case (k)
      0:       r = ANG_W'(843314856);
      1:       r = ANG_W'(497837829);
      2:       r = ANG_W'(263043836);
      3:       r = ANG_W'(133525158);
      4:       r = ANG_W'(67021686);
      5:       r = ANG_W'(33543515);
      6:       r = ANG_W'(16775850);
      7:       r = ANG_W'(8388437);
      8:       r = ANG_W'(4194282);
      9:       r = ANG_W'(2097149);
      10:      r = ANG_W'(1048575);
      11:      r = ANG_W'(524287);
      12:      r = ANG_W'(262143);
      13:      r = ANG_W'(131071);
      14:      r = ANG_W'(65535);
      15:      r = ANG_W'(32767);
      16:      r = ANG_W'(16383);
      17:      r = ANG_W'(8191);
      18:      r = ANG_W'(4095);
      19:      r = ANG_W'(2047);
      20:      r = ANG_W'(1023);
      21:      r = ANG_W'(511);
      22:      r = ANG_W'(255);
      23:      r = ANG_W'(127);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic data_t scale_sample(input sample_t s);
    data_t e;
    e = {{(DATA_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
    return e <<< GUARD_SHIFT;
  endfunction

  function automatic logic signed [RND_W-1:0] round_clamp(input ang_t a,
                                                          input logic signed [RND_W-1:0] lim);
    ang_t                     sum;
    logic signed [RND_W-1:0] v;
    sum = a + RND_HALF_ANG;
    v   = sum[ANG_W-1:OUT_SHIFT];
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/acctr_cordic_pipe.sv -----
`default_nettype none
module acctr_cordic_pipe (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic            zero_i,
  input  wire acctr_pkg::data_t x_i,
  input  wire acctr_pkg::data_t y_i,
  input  wire acctr_pkg::ang_t  ang_i,
  input  wire acctr_pkg::side_t side_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output acctr_pkg::data_t     x_o,
  output acctr_pkg::ang_t      ang_o,
  output acctr_pkg::side_t     side_o
);
  import acctr_pkg::*;

  logic  valid_q [CORDIC_STEPS];
  logic  zero_q  [CORDIC_STEPS];
  data_t x_q     [CORDIC_STEPS];
  data_t y_q     [CORDIC_STEPS];
  ang_t  ang_q   [CORDIC_STEPS];
  side_t side_q  [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic  v_in, z_in;
    data_t x_in, y_in, x_d, y_d;
    ang_t  a_in, a_d;
    side_t s_in;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign z_in = zero_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = ang_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign z_in = zero_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign a_in = ang_q[k-1];
      assign s_in = side_q[k-1];
    end

    // rotate toward the x axis
    always_comb begin
      if (!y_in[DATA_W-1]) begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        a_d = a_in + atan_q30(k);
      end else begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        a_d = a_in - atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k] <= z_in;
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        ang_q[k]  <= a_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS-1];
  assign zero_o  = zero_q[CORDIC_STEPS-1];
  assign x_o     = x_q[CORDIC_STEPS-1];
  assign ang_o   = zero_q[CORDIC_STEPS-1] ? '0 : ang_q[CORDIC_STEPS-1];
  assign side_o  = side_q[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ----- sv/accel_tilt_roll_pitch_unit.sv -----
// path from an accepted input word to its result word
//   (input register, 16 roll cordic stages, gain multiply, 16 pitch stages, output register)
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// reset: asynchronous active low, clears all valid bits, payload registers are not reset
`default_nettype none
module accel_tilt_roll_pitch_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // roll_angle, pitch_angle, zero pad
);
  import acctr_pkg::*;

  logic    adv;
  logic    in_valid_q;
  sample_t in_x_q, in_y_q, in_z_q;

  data_t   ry, rz, rx0, ry0;
  ang_t    ra0;
  logic    rzero;
  side_t   rside;

  logic    roll_valid, roll_zero;
  data_t   roll_mag;
  ang_t    roll_ang;
  side_t   roll_side;

  logic                     mul_valid_q;
  logic signed [PROD_W-1:0] mul_prod_q;
  side_t                    mul_side_q;

  data_t   p_mag, p_num;
  logic    p_zero;
  side_t   p_side;

  logic    pit_valid, pit_zero;
  data_t   pit_x;
  ang_t    pit_ang;
  side_t   pit_side;

  logic signed [RND_W-1:0] roll_rnd, pitch_rnd;
  logic                    out_valid_q;
  logic [ROLL_W-1:0]       out_roll_q;
  logic [PITCH_W-1:0]      out_pitch_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q  <= s_axis_tvalid;
      mul_valid_q <= roll_valid;
      out_valid_q <= pit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_x_q      <= s_axis_tdata[15:0];
      in_y_q      <= s_axis_tdata[31:16];
      in_z_q      <= s_axis_tdata[47:32];
      mul_prod_q  <= {{GAIN_W{roll_mag[DATA_W-1]}}, roll_mag} *
                     PROD_W'(INV_GAIN);
      out_roll_q  <= ROLL_W'(roll_rnd);
      out_pitch_q <= PITCH_W'(pitch_rnd);
    end
  end

  // roll: left half plane folded by a quarter turn
  always_comb begin
    ry    = scale_sample(in_y_q);
    rz    = scale_sample(in_z_q);
    rzero = (in_y_q == '0) && (in_z_q == '0);
    rx0   = rz;
    ry0   = ry;
    ra0   = '0;
    if (rz[DATA_W-1]) begin
      if (!ry[DATA_W-1]) begin
        rx0 = ry;
        ry0 = -rz;
        ra0 = HALF_PI_ANG;
      end else begin
        rx0 = -ry;
        ry0 = rz;
        ra0 = -HALF_PI_ANG;
      end
    end
    rside.raw_x    = in_x_q;
    rside.roll_ang = '0;
  end

  acctr_cordic_pipe u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_q),
    .zero_i  (rzero),
    .x_i     (rx0),
    .y_i     (ry0),
    .ang_i   (ra0),
    .side_i  (rside),
    .valid_o (roll_valid),
    .zero_o  (roll_zero),
    .x_o     (roll_mag),
    .ang_o   (roll_ang),
    .side_o  (roll_side)
  );

  // gain-corrected magnitude against -x
  always_comb begin
    p_mag           = mul_prod_q[INV_GAIN_SHIFT +: DATA_W];
    p_num           = -scale_sample(mul_side_q.raw_x);
    p_zero          = (mul_side_q.raw_x == '0) && (p_mag == '0);
    p_side          = mul_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_side_q.raw_x    <= roll_side.raw_x;
      mul_side_q.roll_ang <= roll_zero ? '0 : roll_ang;
    end
  end

  acctr_cordic_pipe u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (mul_valid_q),
    .zero_i  (p_zero),
    .x_i     (p_mag),
    .y_i     (p_num),
    .ang_i   ('0),
    .side_i  (p_side),
    .valid_o (pit_valid),
    .zero_o  (pit_zero),
    .x_o     (pit_x),
    .ang_o   (pit_ang),
    .side_o  (pit_side)
  );

  always_comb begin
    roll_rnd  = round_clamp(pit_side.roll_ang, ROLL_LIM);
    pitch_rnd = pit_zero ? '0 : round_clamp(pit_ang, PITCH_LIM);
    if (pit_x == '0 && pit_zero) begin
      pitch_rnd = '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pitch_q, out_roll_q};

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acctr_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_SAMPLES = 750;
  localparam int PIPE_LATENCY = 35;
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT = 10;

  typedef enum int {AXIS_FULL, AXIS_NEAR_ZERO, AXIS_EDGE} axis_mode_e;

  class tilt_scoreboard;
    typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
    } angles_t;

    angles_t pending_angles[$];
    int      samples_seen;
    int      angles_checked;
    int      mismatches;
    longint  arctan_q30[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
    };

    // vectoring rotation, angle of (den, num) in q30, radius gets gain * length
    function longint vector_angle(longint num, longint den, output longint radius);
      longint xv, yv, ang, dx, dy, t;
      int     i;
      radius = 0;
      if (num == 0 && den == 0) begin
        return 0;
      end
      xv  = den;
      yv  = num;
      ang = 0;
      if (xv < 0) begin
        if (yv >= 0) begin
          t   = xv;
          xv  = yv;
          yv  = -t;
          ang = HALF_PI_Q30;
        end else begin
          t   = xv;
          xv  = -yv;
          yv  = t;
          ang = -HALF_PI_Q30;
        end
      end
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv  = xv + dx;
          yv  = yv - dy;
          ang = ang + arctan_q30[i];
        end else begin
          xv  = xv - dx;
          yv  = yv + dy;
          ang = ang - arctan_q30[i];
        end
      end
      radius = xv;
      return ang;
    endfunction

    function longint to_fixed(longint ang, longint lim_q30);
      longint half, v, lim;
      half = longint'(1) <<< (OUT_SHIFT - 1);
      v    = (ang + half) >>> OUT_SHIFT;
      lim  = (lim_q30 + half) >>> OUT_SHIFT;
      if (v > lim) begin
        v = lim;
      end else if (v < -lim) begin
        v = -lim;
      end
      return v;
    endfunction

    function angles_t tilt_angles(sample_t x, sample_t y, sample_t z);
      longint  ax, ay, az, radius, scratch, roll, pitch;
      angles_t a;
      ax      = longint'(x) <<< GUARD_SHIFT;
      ay      = longint'(y) <<< GUARD_SHIFT;
      az      = longint'(z) <<< GUARD_SHIFT;
      roll    = vector_angle(ay, az, radius);
      radius  = (radius * longint'(INV_GAIN)) >>> INV_GAIN_SHIFT;
      pitch   = vector_angle(-ax, radius, scratch);
      a.roll  = ROLL_W'(to_fixed(roll, PI_Q30));
      a.pitch = PITCH_W'(to_fixed(pitch, HALF_PI_Q30));
      return a;
    endfunction

    function void note_sample(sample_t x, sample_t y, sample_t z);
      pending_angles.push_back(tilt_angles(x, y, z));
      samples_seen++;
    endfunction

    function void check_result(logic signed [ROLL_W-1:0] roll,
                               logic signed [PITCH_W-1:0] pitch);
      angles_t want;
      angles_checked++;
      if (pending_angles.size() == 0) begin
        $error("angle word with no sample pending: roll %0d pitch %0d", roll, pitch);
        mismatches++;
        return;
      end
      want = pending_angles.pop_front();
      if (roll !== want.roll) begin
        $error("roll_angle: expected %0d, got %0d", want.roll, roll);
        mismatches++;
      end
      if (pitch !== want.pitch) begin
        $error("pitch_angle: expected %0d, got %0d", want.pitch, pitch);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  logic [47:0] sample_word = '0;  // accel_x, accel_y, accel_z
  logic        angle_valid;
  logic        angle_ready = 1'b0;
  logic [31:0] angle_word;        // roll_angle, pitch_angle, zero pad
  int          stalled_cycles = 0;

  tilt_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  accel_tilt_roll_pitch_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (sample_valid),
    .s_axis_tready (sample_ready),
    .s_axis_tdata  (sample_word),
    .m_axis_tvalid (angle_valid),
    .m_axis_tready (angle_ready),
    .m_axis_tdata  (angle_word)
  );

  task automatic send_sample(int x, int y, int z);
    sample_valid <= 1'b1;
    sample_word  <= {16'(z), 16'(y), 16'(x)};
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sb.note_sample(sample_t'(x), sample_t'(y), sample_t'(z));
  endtask

  task automatic maybe_pause(bit allow);
    if (allow && $urandom_range(99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic sample_t pick_axis(axis_mode_e m);
    sample_t v;
    case (m)
      AXIS_NEAR_ZERO: begin
        v = sample_t'($urandom_range(16)) - sample_t'(8);
      end
      AXIS_EDGE: begin
        case ($urandom_range(5))
          0:       v = 16'sh8000;
          1:       v = 16'sh8001;
          2:       v = -16'sd1;
          3:       v = 16'sd0;
          4:       v = 16'sd1;
          default: v = 16'sh7fff;
        endcase
      end
      default: begin
        v = sample_t'($urandom());
      end
    endcase
    return v;
  endfunction

  // sample side
  initial begin
    int         n, pick;
    sample_t    x, y, z;
    axis_mode_e mx, my, mz;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(0, 0, 0);
    send_sample(0, 0, 1000);
    send_sample(0, 0, -1000);
    send_sample(0, 1000, 0);
    send_sample(0, -1000, 0);
    send_sample(0, 1, -32768);
    maybe_pause(1'b1);
    send_sample(0, -1, -32768);
    send_sample(-32768, 0, 0);
    send_sample(32767, 0, 0);
    send_sample(1, 0, 0);
    send_sample(-1, 0, 0);
    send_sample(32767, 32767, 32767);
    maybe_pause(1'b1);
    send_sample(-32768, -32768, -32768);
    send_sample(0, 32767, -32768);
    send_sample(0, -32768, -32768);
    send_sample(0, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(100, 0, -100);
    send_sample(32767, 1, 0);
    send_sample(-32768, 0, -1);
    send_sample(5, -3, 7);
    send_sample(0, 0, 32767);
    send_sample(0, 0, -32768);

    for (n = 0; n < RANDOM_SAMPLES; n++) begin
      maybe_pause(!(n >= 300 && n < 450));
      pick = $urandom_range(99);
      if (pick < 60) begin
        mx = AXIS_FULL;
        my = AXIS_FULL;
        mz = AXIS_FULL;
      end else if (pick < 75) begin
        mx = AXIS_NEAR_ZERO;
        my = AXIS_NEAR_ZERO;
        mz = AXIS_NEAR_ZERO;
      end else begin
        mx = axis_mode_e'($urandom_range(2));
        my = axis_mode_e'($urandom_range(2));
        mz = axis_mode_e'($urandom_range(2));
      end
      x = pick_axis(mx);
      y = pick_axis(my);
      z = pick_axis(mz);
      // roll near the negative z axis
      if (pick >= 92) begin
        y = pick_axis(AXIS_NEAR_ZERO);
        z = -sample_t'($urandom_range(32767, 1));
      end
      send_sample(x, y, z);
    end
    sample_valid <= 1'b0;

    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d angle words checked, %0d mismatches",
             sb.samples_seen, sb.angles_checked, sb.mismatches);
    $display("%s %0d cycle output hold",
             "zero vectors, axis extremes, left half plane roll, idle-free stretches and a",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // angle side
  initial begin
    int results, hold;
    results = 0;
    hold    = 0;
    forever begin
      @(posedge clk);
      if (angle_valid && angle_ready) begin
        sb.check_result(angle_word[15:0], angle_word[30:16]);
        results++;
        if (results == HOLD_AFTER) begin
          hold = HOLD_CYCLES;
        end
      end
      if (hold > 0) begin
        angle_ready <= 1'b0;
        hold--;
      end else if (results >= 500 && results < 650) begin
        angle_ready <= 1'b1;
      end else begin
        angle_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (sample_valid && sample_ready) || (angle_valid && angle_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles = stalled_cycles + 1;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
`default_nettype wire
